// ===== sv/pdfm_pkg.sv =====
// pdfm_pkg: shared constants, capture request type and back-end state type
package pdfm_pkg;

  localparam int COUNT_W    = 32;
  localparam int DUR_W      = 32;
  localparam int RATE_W     = 24;
  localparam int PER_W      = DUR_W + 1;
  localparam int DUTY_W     = 16;
  localparam int FREQ_W     = 34;
  localparam int STEP_W     = $clog2(FREQ_W + 1);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(15625);
  localparam logic [FREQ_W-1:0] MILLI       = FREQ_W'(1000);
  localparam logic [STEP_W-1:0] DUTY_STEPS  = STEP_W'(DUTY_W);
  localparam logic [STEP_W-1:0] FREQ_STEPS  = STEP_W'(FREQ_W);

  typedef struct packed {
    logic             was_rising;
    logic [DUR_W-1:0] hi;
    logic [DUR_W-1:0] lo;
  } capture_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DUTY,
    B_FREQ,
    B_HOLD
  } back_state_t;

endpackage

// ===== sv/pdfm_front.sv =====
// pdfm_front: tick counter, edge capture and duration update
module pdfm_front import pdfm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  logic     level,
  output logic     push,
  output capture_t push_data
);

  logic [COUNT_W-1:0] tick_count;
  logic [COUNT_W-1:0] rise_stamp;
  logic [COUNT_W-1:0] fall_stamp;
  logic [DUR_W-1:0]   high_time;
  logic [DUR_W-1:0]   low_time;
  logic               expect_rising;
  logic               prev_level;

  logic               cap_rise;
  logic               cap_fall;
  logic [DUR_W-1:0]   high_time_next;
  logic [DUR_W-1:0]   low_time_next;

  always_comb begin
    cap_rise       = expect_rising && level && !prev_level;
    cap_fall       = !expect_rising && !level && prev_level;
    high_time_next = cap_rise ? DUR_W'(tick_count - fall_stamp) : high_time;
    low_time_next  = cap_fall ? DUR_W'(tick_count - rise_stamp) : low_time;
    push                 = accept && (cap_rise || cap_fall);
    push_data.was_rising = cap_rise;
    push_data.hi         = high_time_next;
    push_data.lo         = low_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      rise_stamp    <= '0;
      fall_stamp    <= '0;
      high_time     <= '0;
      low_time      <= '0;
      expect_rising <= 1'b1;
      prev_level    <= 1'b0;
    end else if (accept) begin
      if (cap_rise) begin
        rise_stamp <= tick_count;
      end
      if (cap_fall) begin
        fall_stamp <= tick_count;
      end
      if (cap_rise || cap_fall) begin
        expect_rising <= !expect_rising;
      end
      high_time  <= high_time_next;
      low_time   <= low_time_next;
      prev_level <= level;
      tick_count <= tick_count + COUNT_W'(1);
    end
  end

endmodule

// ===== sv/pdfm_queue.sv =====
// pdfm_queue: short request queue between capture front end and arithmetic back end
module pdfm_queue import pdfm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  capture_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output capture_t pop_data
);

  capture_t          entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full      = (fill == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== sv/pdfm_back.sv =====
// pdfm_back: period, duty and frequency by a shared bit-serial divider, output register
module pdfm_back import pdfm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [RATE_W-1:0] tick_rate,
  input  logic              q_not_empty,
  input  capture_t          q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              edge_was_rising,
  output logic [DUR_W-1:0]  high_ticks,
  output logic [DUR_W-1:0]  low_ticks,
  output logic [PER_W-1:0]  period_ticks,
  output logic [DUTY_W-1:0] duty_fraction,
  output logic [FREQ_W-1:0] freq_millihz,
  output logic              estimate_valid
);

  back_state_t        state;
  back_state_t        state_next;

  capture_t           rec;
  logic [PER_W-1:0]   period;
  logic               est_ok;
  logic [FREQ_W-1:0]  prod;
  logic [DUTY_W-1:0]  duty_r;
  logic [FREQ_W-1:0]  freq_r;

  logic [FREQ_W-1:0]  rem;
  logic [FREQ_W-1:0]  num;
  logic [FREQ_W-1:0]  quo;
  logic [STEP_W-1:0]  steps;

  logic [FREQ_W-1:0]  rem_sh;
  logic               fits;
  logic [FREQ_W-1:0]  rem_next;
  logic [FREQ_W-1:0]  quo_next;
  logic               last_step;
  logic               load_out;

  always_comb begin
    rem_sh    = {rem[FREQ_W-2:0], num[FREQ_W-1]};
    fits      = (rem_sh >= FREQ_W'(period));
    rem_next  = fits ? (rem_sh - FREQ_W'(period)) : rem_sh;
    quo_next  = {quo[FREQ_W-2:0], fits};
    last_step = (steps == STEP_W'(1));
    load_out  = (state == B_HOLD) && (!out_valid || out_ready);
    pop       = (state == B_IDLE) && q_not_empty;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_not_empty) begin
          state_next = (q_data.hi != '0 && q_data.lo != '0) ? B_DUTY : B_HOLD;
        end
      end
      B_DUTY: begin
        if (last_step) begin
          state_next = B_FREQ;
        end
      end
      B_FREQ: begin
        if (last_step) begin
          state_next = B_HOLD;
        end
      end
      B_HOLD: begin
        if (load_out) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (q_not_empty) begin
          rec    <= q_data;
          period <= PER_W'(q_data.hi) + PER_W'(q_data.lo);
          est_ok <= (q_data.hi != '0) && (q_data.lo != '0);
          prod   <= FREQ_W'(tick_rate) * MILLI;
          rem    <= FREQ_W'(q_data.hi);
          num    <= '0;
          quo    <= '0;
          steps  <= DUTY_STEPS;
          duty_r <= '0;
          freq_r <= '0;
        end
      end
      B_DUTY: begin
        if (last_step) begin
          duty_r <= quo_next[DUTY_W-1:0];
          rem    <= '0;
          num    <= prod;
          quo    <= '0;
          steps  <= FREQ_STEPS;
        end else begin
          rem   <= rem_next;
          num   <= {num[FREQ_W-2:0], 1'b0};
          quo   <= quo_next;
          steps <= steps - STEP_W'(1);
        end
      end
      B_FREQ: begin
        rem   <= rem_next;
        num   <= {num[FREQ_W-2:0], 1'b0};
        quo   <= quo_next;
        steps <= steps - STEP_W'(1);
        if (last_step) begin
          freq_r <= quo_next;
        end
      end
      B_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      edge_was_rising <= rec.was_rising;
      high_ticks      <= rec.hi;
      low_ticks       <= rec.lo;
      period_ticks    <= period;
      duty_fraction   <= duty_r;
      freq_millihz    <= freq_r;
      estimate_valid  <= est_ok;
    end
  end

  // divider never runs on a zero period
  a_div_period: assert property (@(posedge clk) disable iff (rst)
    (state == B_DUTY || state == B_FREQ) |-> (period != '0))
    else $error("divider running with zero period");

  // invalid estimates carry zero duty and frequency
  a_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !estimate_valid) |-> (duty_fraction == '0 && freq_millihz == '0))
    else $error("nonzero duty or frequency on invalid estimate");

  // reported period matches the reported durations
  a_period_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (period_ticks == PER_W'(high_ticks) + PER_W'(low_ticks)))
    else $error("period does not match high plus low");

  // a request is taken from the queue only when the engine is idle
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != B_IDLE))
    else $error("pop without leaving idle");

endmodule

// ===== sv/pwm_duty_frequency_meter_unit.sv =====
// pwm_duty_frequency_meter_unit: top level of the pwm duty and frequency meter
// input side takes one tick per cycle; in_ready drops only while the 4-deep queue is full
// a capture result passes in order through the back end, once it is free: the pop from the queue,
//   16-bit duty divide, 34-bit frequency divide, then the hold state that loads the output
// the back end takes a new capture only after the last has left the hold state, as the divider is shared;
//   a capture with a zero duration skips the divider and goes straight to the hold state
// synchronous active-high reset clears counters, stamps, durations, queue and output valid;
//   tick rate returns to 15625 hz
module pwm_duty_frequency_meter_unit import pdfm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              comparator_level,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              edge_was_rising,
  output logic [DUR_W-1:0]  high_ticks,
  output logic [DUR_W-1:0]  low_ticks,
  output logic [PER_W-1:0]  period_ticks,
  output logic [DUTY_W-1:0] duty_fraction,
  output logic [FREQ_W-1:0] freq_millihz,
  output logic              estimate_valid
);

  logic [RATE_W-1:0] tick_rate_hz;
  logic              accept;
  logic              push;
  capture_t          push_data;
  logic              q_full;
  logic              q_not_empty;
  capture_t          q_data;
  logic              pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate_hz <= RATE_RESET;
    end else if (cfg_we) begin
      tick_rate_hz <= cfg_data;
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  pdfm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .level     (comparator_level),
    .push      (push),
    .push_data (push_data)
  );

  pdfm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  pdfm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .tick_rate       (tick_rate_hz),
    .q_not_empty     (q_not_empty),
    .q_data          (q_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .edge_was_rising (edge_was_rising),
    .high_ticks      (high_ticks),
    .low_ticks       (low_ticks),
    .period_ticks    (period_ticks),
    .duty_fraction   (duty_fraction),
    .freq_millihz    (freq_millihz),
    .estimate_valid  (estimate_valid)
  );

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for the pwm duty and frequency meter with a tick-level predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pdfm_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic              rising;
    logic [DUR_W-1:0]  hi;
    logic [DUR_W-1:0]  lo;
    logic [PER_W-1:0]  per;
    logic [DUTY_W-1:0] duty;
    logic [FREQ_W-1:0] freq;
    logic              ok;
  } pwm_meas_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [RATE_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              comparator_level = 1'b0;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              edge_was_rising;
  logic [DUR_W-1:0]  high_ticks;
  logic [DUR_W-1:0]  low_ticks;
  logic [PER_W-1:0]  period_ticks;
  logic [DUTY_W-1:0] duty_fraction;
  logic [FREQ_W-1:0] freq_millihz;
  logic              estimate_valid;

  // predicted meter state
  logic [COUNT_W-1:0] tick_count;
  logic [COUNT_W-1:0] rise_at;
  logic [COUNT_W-1:0] fall_at;
  logic [DUR_W-1:0]   high_dur;
  logic [DUR_W-1:0]   low_dur;
  logic               want_rise;
  logic               last_level;
  logic [RATE_W-1:0]  rate_hz;

  pwm_meas_t meas_expected[$];
  int        errors = 0;
  int        cycles = 0;
  int        ticks_sent = 0;
  bit        idling = 1'b1;
  logic      sink_hold = 1'b0;

  always #2ns clk = ~clk;

  pwm_duty_frequency_meter_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .comparator_level (comparator_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .edge_was_rising  (edge_was_rising),
    .high_ticks       (high_ticks),
    .low_ticks        (low_ticks),
    .period_ticks     (period_ticks),
    .duty_fraction    (duty_fraction),
    .freq_millihz     (freq_millihz),
    .estimate_valid   (estimate_valid)
  );

  function automatic void clear_meter_model();
    tick_count = '0;
    rise_at    = '0;
    fall_at    = '0;
    high_dur   = '0;
    low_dur    = '0;
    want_rise  = 1'b1;
    last_level = 1'b0;
    rate_hz    = RATE_RESET;
  endfunction

  function automatic void capture_tick(input logic lvl);
    pwm_meas_t m;
    logic [63:0] per;
    logic [63:0] q;
    logic took;
    took = 1'b0;
    m = '0;
    if (want_rise && lvl && !last_level) begin
      rise_at = tick_count;
      high_dur = DUR_W'(rise_at - fall_at);
      took = 1'b1;
      m.rising = 1'b1;
    end else if (!want_rise && !lvl && last_level) begin
      fall_at = tick_count;
      low_dur = DUR_W'(fall_at - rise_at);
      took = 1'b1;
    end
    if (took) want_rise = !want_rise;
    last_level = lvl;
    tick_count = tick_count + 1'b1;
    if (took) begin
      m.hi = high_dur;
      m.lo = low_dur;
      per = 64'(high_dur) + 64'(low_dur);
      m.per = PER_W'(per);
      m.ok = (high_dur != '0) && (low_dur != '0);
      if (m.ok) begin
        q = (64'(high_dur) << 16) / per;
        if (q > 64'hFFFF) q = 64'hFFFF;
        m.duty = DUTY_W'(q);
        m.freq = FREQ_W'((64'(rate_hz) * 64'd1000) / per);
      end
      meas_expected.push_back(m);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 70);
  endfunction

  task automatic send_tick(input logic lvl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    comparator_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    capture_tick(lvl);
    ticks_sent++;
  endtask

  task automatic send_run(input logic lvl, input int len);
    repeat (len) send_tick(lvl);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (meas_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_tick_rate(input logic [RATE_W-1:0] hz);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= hz;
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_hz = hz;
  endtask

  // alternating levels so every run ends on an edge; single-tick runs act as glitches
  task automatic pulse_train(input int n);
    int stop;
    int len;
    int r;
    logic lvl;
    stop = ticks_sent + n;
    lvl = !last_level;
    while (ticks_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 65) len = $urandom_range(1, 6);
      else if (r < 95) len = $urandom_range(7, 40);
      else len = $urandom_range(41, 160);
      send_run(lvl, len);
      lvl = !lvl;
    end
  endtask

  task automatic hold_sink(input int n);
    sink_hold <= 1'b1;
    repeat (n) @(posedge clk);
    sink_hold <= 1'b0;
  endtask

  // first tick high gives a rising edge at count zero, then one-tick pulses and lopsided ones
  task automatic test_directed_edges();
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 8);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 8);
    send_run(1'b1, 1);
  endtask

  task automatic test_rate_extremes();
    logic [RATE_W-1:0] rates[5];
    rates = '{RATE_W'(0), RATE_W'(1), RATE_W'(16000000), {RATE_W{1'b1}}, RATE_RESET};
    foreach (rates[i]) begin
      set_tick_rate(rates[i]);
      pulse_train(20);
    end
  endtask

  task automatic test_output_backpressure();
    settle();
    idling = 1'b0;
    fork
      hold_sink(HOLD_CYCLES);
    join_none
    for (int i = 0; i < 40; i++) send_tick(logic'(i[0] ^ !last_level));
    idling = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      set_tick_rate(RATE_W'($urandom_range(1, 16000000)));
      idling = (phase != 2);
      pulse_train(240);
    end
    idling = 1'b1;
  endtask

  initial begin : result_check
    pwm_meas_t want;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (meas_expected.size() == 0) begin
          $error("unexpected result: high_ticks %0d low_ticks %0d", high_ticks, low_ticks);
          errors++;
        end else begin
          want = meas_expected.pop_front();
          if (edge_was_rising !== want.rising) begin
            $error("edge_was_rising: expected %0d, got %0d", want.rising, edge_was_rising);
            errors++;
          end
          if (high_ticks !== want.hi) begin
            $error("high_ticks: expected %0d, got %0d", want.hi, high_ticks);
            errors++;
          end
          if (low_ticks !== want.lo) begin
            $error("low_ticks: expected %0d, got %0d", want.lo, low_ticks);
            errors++;
          end
          if (period_ticks !== want.per) begin
            $error("period_ticks: expected %0d, got %0d", want.per, period_ticks);
            errors++;
          end
          if (duty_fraction !== want.duty) begin
            $error("duty_fraction: expected %0d, got %0d", want.duty, duty_fraction);
            errors++;
          end
          if (freq_millihz !== want.freq) begin
            $error("freq_millihz: expected %0d, got %0d", want.freq, freq_millihz);
            errors++;
          end
          if (estimate_valid !== want.ok) begin
            $error("estimate_valid: expected %0d, got %0d", want.ok, estimate_valid);
            errors++;
          end
        end
      end
      if (sink_hold) begin
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (idling && $urandom_range(0, 5) == 0) stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    clear_meter_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_rate_extremes();
    test_output_backpressure();
    test_random_traffic();
    settle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
